// File: rtl/fss_pkg.sv
// fss_pkg: shared types, state codes, register indexes and reset values for the fan supervisor
`timescale 1ns / 1ps
package fss_pkg;

   localparam int TimeWidthDefault = 48;
   localparam int CsrIndexWidth    = 3;
   localparam int CsrDataWidth     = 32;

   // fan state codes
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_STARTING = 3'd1;
   localparam logic [2:0] ST_RUNNING  = 3'd2;
   localparam logic [2:0] ST_STALL    = 3'd3;
   localparam logic [2:0] ST_CALIB    = 3'd4;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] REG_MIN_FAN_SPEED      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_TEMP_ON_THRESHOLD  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_SPEED_OK_THRESHOLD = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_START_TIMEOUT      = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_RUN_TIMEOUT        = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_CALIB_SPEED        = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_CALIB_DURATION     = 3'd6;

   // register reset values
   localparam logic [15:0] RST_MIN_FAN_SPEED      = 16'd0;
   localparam logic [11:0] RST_TEMP_ON_THRESHOLD  = 12'd240;
   localparam logic [15:0] RST_SPEED_OK_THRESHOLD = 16'd300;
   localparam logic [31:0] RST_START_TIMEOUT      = 32'd500000;
   localparam logic [31:0] RST_RUN_TIMEOUT        = 32'd1000000;
   localparam logic [15:0] RST_CALIB_SPEED        = 16'd2500;
   localparam logic [31:0] RST_CALIB_DURATION     = 32'd5000000;

   typedef struct packed {
      logic [15:0] min_fan_speed;
      logic [11:0] temp_on_threshold;
      logic [15:0] speed_ok_threshold;
      logic [31:0] start_timeout;
      logic [31:0] run_timeout;
      logic [15:0] calib_speed;
      logic [31:0] calib_duration;
   } fss_cfg_type;

   typedef struct packed {
      logic [2:0]  fsm_state;
      logic [2:0]  last_reported_state;
      logic        calib_active;
      logic [15:0] applied_target;
      logic        applied_target_valid;
   } fss_ctrl_type;

   typedef struct packed {
      logic [2:0]  fan_state;
      logic [15:0] target_speed;
      logic        target_changed;
      logic        notify_valid;
      logic [2:0]  notify_state;
      logic        calib_accepted;
      logic        calibrating;
   } fss_result_type;

endpackage

// File: rtl/fan_stall_supervisor_unit.sv
// fan_stall_supervisor_unit: top level of the fan stall supervisor
`timescale 1ns / 1ps
// Each request on the req_ channel is one control tick: timestamp, measured
// speed, temperature with valid bits and a calibration request. For every
// request one response leaves on the rsp_ channel with the fan state, the
// commanded target, the target-changed flag, a state notification and the
// calibration status.
// Requests land in an input register; once the response register is free,
// the tick runs through the step logic, updates the supervisor state and
// loads the response register.
// Throughput is one request per cycle: the input register moves on whenever
// the response register is empty or being taken in the same cycle.
// When the receiver stalls, the response is held and one more request waits
// in the input register; req_ready then drops until rsp_ready returns.
// Thresholds and timeouts are written via csr_we/csr_index/csr_wdata, one
// register per cycle; the user must write only with no request in flight (unenforced).
// Reset (synchronous) restores the register defaults, puts the fan in idle
// with no target applied and no calibration running, and empties both stages.
module fan_stall_supervisor_unit
   import fss_pkg::*;
#(
   parameter int TIME_WIDTH = TimeWidthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [TIME_WIDTH-1:0]    req_now_time,
   input  logic [15:0]              req_fan_speed,
   input  logic                     req_speed_valid,
   input  logic signed [11:0]       req_temperature,
   input  logic                     req_temp_valid,
   input  logic                     req_calib_request,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_fan_state,
   output logic [15:0]              rsp_target_speed,
   output logic                     rsp_target_changed,
   output logic                     rsp_notify_valid,
   output logic [2:0]               rsp_notify_state,
   output logic                     rsp_calib_accepted,
   output logic                     rsp_calibrating
);

   fss_cfg_type           cfg_ff;

   logic                  in_valid_ff;
   logic [TIME_WIDTH-1:0] in_now_ff;
   logic [15:0]           in_speed_ff;
   logic                  in_speed_valid_ff;
   logic signed [11:0]    in_temp_ff;
   logic                  in_temp_valid_ff;
   logic                  in_calib_req_ff;

   fss_ctrl_type          ctrl_ff;
   fss_ctrl_type          ctrl_in;
   logic [TIME_WIDTH-1:0] entry_time_ff;
   logic [TIME_WIDTH-1:0] entry_time_in;
   logic [TIME_WIDTH-1:0] good_time_ff;
   logic [TIME_WIDTH-1:0] good_time_in;
   logic [TIME_WIDTH-1:0] calib_start_ff;
   logic [TIME_WIDTH-1:0] calib_start_in;

   fss_result_type        result_in;
   fss_result_type        result_ff;
   logic                  rsp_valid_ff;

   logic                  advance;
   logic                  req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_fan_speed      <= RST_MIN_FAN_SPEED;
         cfg_ff.temp_on_threshold  <= RST_TEMP_ON_THRESHOLD;
         cfg_ff.speed_ok_threshold <= RST_SPEED_OK_THRESHOLD;
         cfg_ff.start_timeout      <= RST_START_TIMEOUT;
         cfg_ff.run_timeout        <= RST_RUN_TIMEOUT;
         cfg_ff.calib_speed        <= RST_CALIB_SPEED;
         cfg_ff.calib_duration     <= RST_CALIB_DURATION;
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_FAN_SPEED:      cfg_ff.min_fan_speed      <= csr_wdata[15:0];
            REG_TEMP_ON_THRESHOLD:  cfg_ff.temp_on_threshold  <= csr_wdata[11:0];
            REG_SPEED_OK_THRESHOLD: cfg_ff.speed_ok_threshold <= csr_wdata[15:0];
            REG_START_TIMEOUT:      cfg_ff.start_timeout      <= csr_wdata;
            REG_RUN_TIMEOUT:        cfg_ff.run_timeout        <= csr_wdata;
            REG_CALIB_SPEED:        cfg_ff.calib_speed        <= csr_wdata[15:0];
            REG_CALIB_DURATION:     cfg_ff.calib_duration     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff         <= req_now_time;
         in_speed_ff       <= req_fan_speed;
         in_speed_valid_ff <= req_speed_valid;
         in_temp_ff        <= req_temperature;
         in_temp_valid_ff  <= req_temp_valid;
         in_calib_req_ff   <= req_calib_request;
      end
   end

   fss_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .now_time         (in_now_ff),
      .fan_speed        (in_speed_ff),
      .speed_valid      (in_speed_valid_ff),
      .temperature      (in_temp_ff),
      .temp_valid       (in_temp_valid_ff),
      .calib_request    (in_calib_req_ff),
      .cfg              (cfg_ff),
      .ctrl             (ctrl_ff),
      .entry_time       (entry_time_ff),
      .good_time        (good_time_ff),
      .calib_start      (calib_start_ff),
      .ctrl_next        (ctrl_in),
      .entry_time_next  (entry_time_in),
      .good_time_next   (good_time_in),
      .calib_start_next (calib_start_in),
      .result           (result_in)
   );

   // supervisor state, updated once per processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.fsm_state            <= ST_IDLE;
         ctrl_ff.last_reported_state  <= ST_IDLE;
         ctrl_ff.calib_active         <= 1'b0;
         ctrl_ff.applied_target       <= 16'd0;
         ctrl_ff.applied_target_valid <= 1'b0;
         entry_time_ff                <= '0;
         good_time_ff                 <= '0;
         calib_start_ff               <= '0;
      end else if (advance) begin
         ctrl_ff        <= ctrl_in;
         entry_time_ff  <= entry_time_in;
         good_time_ff   <= good_time_in;
         calib_start_ff <= calib_start_in;
      end
   end

   // response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fan_state      = result_ff.fan_state;
   assign rsp_target_speed   = result_ff.target_speed;
   assign rsp_target_changed = result_ff.target_changed;
   assign rsp_notify_valid   = result_ff.notify_valid;
   assign rsp_notify_state   = result_ff.notify_state;
   assign rsp_calib_accepted = result_ff.calib_accepted;
   assign rsp_calibrating    = result_ff.calibrating;

endmodule

// File: rtl/fss_step.sv
// fss_step: next-state and result logic for one control tick
`timescale 1ns / 1ps
module fss_step
   import fss_pkg::*;
#(
   parameter int TIME_WIDTH = TimeWidthDefault
) (
   input  logic [TIME_WIDTH-1:0] now_time,
   input  logic [15:0]           fan_speed,
   input  logic                  speed_valid,
   input  logic signed [11:0]    temperature,
   input  logic                  temp_valid,
   input  logic                  calib_request,
   input  fss_cfg_type           cfg,
   input  fss_ctrl_type          ctrl,
   input  logic [TIME_WIDTH-1:0] entry_time,
   input  logic [TIME_WIDTH-1:0] good_time,
   input  logic [TIME_WIDTH-1:0] calib_start,
   output fss_ctrl_type          ctrl_next,
   output logic [TIME_WIDTH-1:0] entry_time_next,
   output logic [TIME_WIDTH-1:0] good_time_next,
   output logic [TIME_WIDTH-1:0] calib_start_next,
   output fss_result_type        result
);

   logic                  speed_ok;
   logic [15:0]           target;
   logic [2:0]            st;
   logic [2:0]            cur;
   logic [2:0]            rep;
   logic                  act;
   logic                  accepted;
   logic                  nv;
   logic [2:0]            ns;
   logic                  changed;
   logic [15:0]           lt;
   logic                  ltv;
   logic [TIME_WIDTH-1:0] entry;
   logic [TIME_WIDTH-1:0] lgood;
   logic [TIME_WIDTH-1:0] cstart;
   logic [TIME_WIDTH-1:0] calib_elapsed;
   logic                  start_expired;
   logic                  run_expired;

   assign speed_ok = speed_valid && (fan_speed >= cfg.speed_ok_threshold);

   // both timeouts use the state's stored times, never updated ones
   assign start_expired = (now_time - entry_time) >= TIME_WIDTH'(cfg.start_timeout);
   assign run_expired   = (now_time - good_time) >= TIME_WIDTH'(cfg.run_timeout);

   assign accepted      = calib_request && !ctrl.calib_active;
   assign cstart        = accepted ? now_time : calib_start;
   assign calib_elapsed = now_time - cstart;
   assign act = (ctrl.calib_active || accepted) &&
                !(calib_elapsed >= TIME_WIDTH'(cfg.calib_duration));

   always_comb begin
      st      = ctrl.fsm_state;
      cur     = ctrl.fsm_state;
      rep     = ctrl.last_reported_state;
      entry   = entry_time;
      lgood   = good_time;
      lt      = ctrl.applied_target;
      ltv     = ctrl.applied_target_valid;
      nv      = 1'b0;
      ns      = ST_IDLE;
      target  = (temp_valid && (temperature > $signed(cfg.temp_on_threshold)))
                ? cfg.min_fan_speed : 16'd0;

      if (act) begin
         if (cur != ST_CALIB) begin
            st    = ST_CALIB;
            entry = now_time;
            if (rep != ST_CALIB) begin
               rep = ST_CALIB;
               nv  = 1'b1;
               ns  = ST_CALIB;
            end
         end
         target = cfg.calib_speed;
      end else begin
         // phase just ended: fall back to idle, then regulate normally
         if (cur == ST_CALIB) begin
            st    = ST_IDLE;
            entry = now_time;
            cur   = ST_IDLE;
            if (rep != ST_IDLE) begin
               rep = ST_IDLE;
               nv  = 1'b1;
               ns  = ST_IDLE;
            end
         end
         if (target == 16'd0) begin
            if (cur != ST_IDLE) begin
               st    = ST_IDLE;
               entry = now_time;
               if (rep != ST_IDLE) begin
                  rep = ST_IDLE;
                  nv  = 1'b1;
                  ns  = ST_IDLE;
               end
            end
         end else begin
            if (speed_ok) begin
               lgood = now_time;
            end
            case (cur)
               ST_IDLE: begin
                  st    = ST_STARTING;
                  entry = now_time;
               end
               ST_STARTING: begin
                  if (speed_ok) begin
                     st    = ST_RUNNING;
                     entry = now_time;
                     lgood = now_time;
                     if (rep != ST_RUNNING) begin
                        rep = ST_RUNNING;
                        nv  = 1'b1;
                        ns  = ST_RUNNING;
                     end
                  end else if (start_expired) begin
                     st    = ST_STALL;
                     entry = now_time;
                     if (rep != ST_STALL) begin
                        rep = ST_STALL;
                        nv  = 1'b1;
                        ns  = ST_STALL;
                     end
                  end
               end
               ST_RUNNING: begin
                  if (!speed_ok && run_expired) begin
                     st    = ST_STALL;
                     entry = now_time;
                     if (rep != ST_STALL) begin
                        rep = ST_STALL;
                        nv  = 1'b1;
                        ns  = ST_STALL;
                     end
                  end else if (speed_ok && rep != ST_RUNNING) begin
                     rep = ST_RUNNING;
                     nv  = 1'b1;
                     ns  = ST_RUNNING;
                  end
               end
               ST_STALL: begin
                  if (speed_ok) begin
                     st    = ST_RUNNING;
                     entry = now_time;
                     lgood = now_time;
                     if (rep != ST_RUNNING) begin
                        rep = ST_RUNNING;
                        nv  = 1'b1;
                        ns  = ST_RUNNING;
                     end
                  end
               end
               default: begin
                  st    = ST_IDLE;
                  entry = now_time;
               end
            endcase
         end
      end

      changed = !(ltv && (target == lt));
      if (changed) begin
         lt  = target;
         ltv = 1'b1;
      end
   end

   assign ctrl_next.fsm_state            = st;
   assign ctrl_next.last_reported_state  = rep;
   assign ctrl_next.calib_active         = act;
   assign ctrl_next.applied_target       = lt;
   assign ctrl_next.applied_target_valid = ltv;
   assign entry_time_next                = entry;
   assign good_time_next                 = lgood;
   assign calib_start_next               = cstart;

   assign result.fan_state      = st;
   assign result.target_speed   = target;
   assign result.target_changed = changed;
   assign result.notify_valid   = nv;
   assign result.notify_state   = ns;
   assign result.calib_accepted = accepted;
   assign result.calibrating    = act;

endmodule
